// File: design/banked_register_file_interrupt_macros.svh
// Assertion helpers shared by the register file modules.
`ifndef BANKED_REGISTER_FILE_INTERRUPT_MACROS_SVH
`define BANKED_REGISTER_FILE_INTERRUPT_MACROS_SVH

// Same-cycle implication, masked during reset.
`define BRFI_ASSERT_NOW(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("brfi check failed");

// Next-cycle implication, masked during reset.
`define BRFI_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("brfi check failed");

`endif

// File: design/brfi_pkg.sv
`default_nettype none

package brfi_pkg;

  typedef logic [15:0] word_t;
  typedef logic [2:0]  rindex_t;
  typedef logic [1:0]  cmd_t;
  typedef logic [1:0]  code_t;

  localparam cmd_t CMD_READ  = 2'd0;
  localparam cmd_t CMD_WRITE = 2'd1;
  localparam cmd_t CMD_ENTER = 2'd2;
  localparam cmd_t CMD_EXIT  = 2'd3;

  localparam code_t ST_OK          = 2'd0;
  localparam code_t ST_IN_ROUTINE  = 2'd1;
  localparam code_t ST_IE_CLEAR    = 2'd2;
  localparam code_t ST_EXIT_OUTSIDE = 2'd3;

  localparam int REG_COUNT = 8;
  localparam rindex_t REG_STATUS = 3'd6;
  localparam rindex_t REG_PC     = 3'd7;
  localparam rindex_t REG_LINK   = 3'd5;
  localparam rindex_t REG_BASE   = 3'd0;

  // Registers 0..5 are the only ones that can ever bank.
  localparam int BANKABLE = 6;

  localparam int BANK_BIT = 5;
  localparam int IE_BIT   = 4;
  localparam word_t STATUS_IN_IRQ = 16'h0020;
  localparam word_t PC_VECTOR     = 16'h0002;

  localparam int DEF_SHADOW_COUNT = 6;

  localparam int TDATA_W = 24;

  typedef struct packed {
    cmd_t    cmd;
    rindex_t idx;
    word_t   val;
  } item_t;

  typedef struct packed {
    word_t data;
    code_t code;
  } result_t;

endpackage

`default_nettype wire

// File: design/brfi_exec.sv
`default_nettype none

`include "banked_register_file_interrupt_macros.svh"

module brfi_exec #(
  parameter int SHADOW_COUNT = brfi_pkg::DEF_SHADOW_COUNT
) (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             fire,
  input  wire brfi_pkg::item_t  item,
  output brfi_pkg::result_t     res
);
  import brfi_pkg::*;

  localparam int MAPPED = (SHADOW_COUNT < BANKABLE) ? SHADOW_COUNT : BANKABLE;
  localparam bit LINK_MAPPED = (int'(REG_LINK) < MAPPED);

  word_t main_regs [REG_COUNT];
  word_t shadow_regs [SHADOW_COUNT];
  word_t main_next [REG_COUNT];
  word_t shadow_next [SHADOW_COUNT];

  word_t status_word;
  word_t pc_word;
  logic  bank;
  logic  ie;
  logic  item_mapped;
  word_t sh_item;
  word_t sh_link;
  word_t rd_item;
  word_t rd_link;
  word_t rd_base;

  assign status_word = main_regs[REG_STATUS];
  assign pc_word     = main_regs[REG_PC];
  assign bank        = status_word[BANK_BIT];
  assign ie          = status_word[IE_BIT];
  assign item_mapped = bank && (item.idx < 3'(MAPPED));

  // Reads through the active mapping.
  always_comb begin
    sh_item = '0;
    sh_link = '0;
    for (int i = 0; i < SHADOW_COUNT; i++) begin
      if (item.idx == 3'(i)) begin
        sh_item = shadow_regs[i];
      end
      if (i == int'(REG_LINK)) begin
        sh_link = shadow_regs[i];
      end
    end
    rd_item = item_mapped ? sh_item : main_regs[item.idx];
    rd_link = (bank && LINK_MAPPED) ? sh_link : main_regs[REG_LINK];
    rd_base = bank ? shadow_regs[0] : main_regs[REG_BASE];
  end

  always_comb begin
    main_next   = main_regs;
    shadow_next = shadow_regs;
    res.data    = '0;
    res.code    = ST_OK;
    case (item.cmd)
      CMD_READ: begin
        res.data = rd_item;
      end
      CMD_WRITE: begin
        if (item_mapped) begin
          for (int i = 0; i < SHADOW_COUNT; i++) begin
            if (item.idx == 3'(i)) begin
              shadow_next[i] = item.val;
            end
          end
        end else begin
          main_next[item.idx] = item.val;
        end
      end
      CMD_ENTER: begin
        if (ie) begin
          // Save status, switch bank, park the PC in the link register.
          shadow_next[0]         = status_word;
          main_next[REG_STATUS]  = STATUS_IN_IRQ;
          main_next[REG_PC]      = PC_VECTOR;
          if (LINK_MAPPED) begin
            for (int i = 0; i < SHADOW_COUNT; i++) begin
              if (i == int'(REG_LINK)) begin
                shadow_next[i] = pc_word;
              end
            end
          end else begin
            main_next[REG_LINK] = pc_word;
          end
        end else if (bank) begin
          res.code = ST_IN_ROUTINE;
        end else begin
          res.code = ST_IE_CLEAR;
        end
      end
      CMD_EXIT: begin
        if (!bank) begin
          res.code = ST_EXIT_OUTSIDE;
        end
        main_next[REG_PC]     = rd_link;
        main_next[REG_STATUS] = rd_base;
      end
      default: begin
        res.code = ST_OK;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < REG_COUNT; i++) begin
        main_regs[i] <= '0;
      end
      for (int i = 0; i < SHADOW_COUNT; i++) begin
        shadow_regs[i] <= '0;
      end
    end else if (fire) begin
      main_regs   <= main_next;
      shadow_regs <= shadow_next;
    end
  end

  `BRFI_ASSERT_NEXT(a_enter_taken, clk, rst, fire && item.cmd == CMD_ENTER && ie,
    main_regs[REG_STATUS] == STATUS_IN_IRQ && main_regs[REG_PC] == PC_VECTOR)
  `BRFI_ASSERT_NEXT(a_enter_refused, clk, rst, fire && item.cmd == CMD_ENTER && !ie,
    main_regs[REG_STATUS] == $past(main_regs[REG_STATUS]))
  `BRFI_ASSERT_NOW(a_exit_code, clk, rst, res.code == ST_EXIT_OUTSIDE,
    item.cmd == CMD_EXIT && !bank)
  `BRFI_ASSERT_NOW(a_data_on_read, clk, rst, res.data != '0, item.cmd == CMD_READ)

endmodule

`default_nettype wire

// File: design/banked_register_file_interrupt.sv
// Banked register file with interrupt entry and exit.
// Input stream (s_*): one word per command: read, write, enter or exit
// interrupt. Output stream (m_*): exactly one word per command, in order,
// carrying the read data (zero unless a read) and a 2-bit status code.
// Registers 6 and 7 are the status word and PC; with status bit 5 set,
// the low registers map to the shadow bank.
// Path: a word accepted into the input register is executed from there, and
// its result is registered into the result register that drives m_tvalid.
// Throughput: one word per cycle while m_tready is high; a command's update
// lands at the edge that registers its result, so the next command sees it.
// Reset (rst, synchronous): all main and shadow registers clear to zero,
// both pipeline registers empty.
// Stall: while m_tready is low the result holds; the input register still
// takes one more word, then s_tready drops until the result is taken.
`default_nettype none

`include "banked_register_file_interrupt_macros.svh"

module banked_register_file_interrupt #(
  parameter int SHADOW_COUNT = brfi_pkg::DEF_SHADOW_COUNT
) (
  input  wire logic                         clk,
  input  wire logic                         rst,
  input  wire logic                         s_tvalid,
  output logic                              s_tready,
  // [1:0] command, [4:2] reg_index, [20:5] write_value, [23:21] zero
  input  wire logic [brfi_pkg::TDATA_W-1:0] s_tdata,
  output logic                              m_tvalid,
  input  wire logic                         m_tready,
  // [15:0] read_data, [17:16] status, [23:18] zero
  output logic [brfi_pkg::TDATA_W-1:0]      m_tdata
);
  import brfi_pkg::*;

  logic    in_valid;
  item_t   in_item;
  logic    out_valid;
  result_t out_res;
  result_t exec_res;
  logic    advance;
  logic    take;

  // Advance the held command when the result slot is free or being taken.
  assign advance  = in_valid && (!out_valid || m_tready);
  assign s_tready = !in_valid || advance;
  assign take     = s_tvalid && s_tready;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (take) begin
      in_valid <= 1'b1;
    end else if (advance) begin
      in_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      in_item.cmd <= s_tdata[1:0];
      in_item.idx <= s_tdata[4:2];
      in_item.val <= s_tdata[20:5];
    end
  end

  brfi_exec #(
    .SHADOW_COUNT(SHADOW_COUNT)
  ) u_exec (
    .clk  (clk),
    .rst  (rst),
    .fire (advance),
    .item (in_item),
    .res  (exec_res)
  );

  // Result register: load on advance, drop once taken.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= 1'b1;
    end else if (m_tready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_res <= exec_res;
    end
  end

  assign m_tvalid = out_valid;
  assign m_tdata  = {6'd0, out_res.code, out_res.data};

  `BRFI_ASSERT_NEXT(a_stage_held, clk, rst, in_valid && !advance, in_valid)
  `BRFI_ASSERT_NOW(a_no_overrun, clk, rst, advance, !out_valid || m_tready)
  `BRFI_ASSERT_NEXT(a_result_loaded, clk, rst, advance, out_valid)

endmodule

`default_nettype wire

// File: verif/regfile_checker.sv
`timescale 1ns / 100ps

module regfile_checker
  import brfi_pkg::*;
#(
  parameter int SHADOW_COUNT = DEF_SHADOW_COUNT
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               s_tvalid,
  input  logic               s_tready,
  input  logic [TDATA_W-1:0] s_tdata,
  input  logic               m_tvalid,
  input  logic               m_tready,
  input  logic [TDATA_W-1:0] m_tdata,
  output int                 fail_count,
  output int                 outstanding
);

  word_t   main_bank [REG_COUNT];
  word_t   shadow_bank [SHADOW_COUNT];
  result_t awaited_results [$];

  initial begin
    fail_count = 0;
    outstanding = 0;
  end

  function automatic bit is_banked(rindex_t idx);
    return main_bank[REG_STATUS][BANK_BIT] && int'(idx) < BANKABLE &&
           int'(idx) < SHADOW_COUNT;
  endfunction

  function automatic word_t fetch_reg(rindex_t idx);
    if (is_banked(idx)) begin
      return shadow_bank[idx];
    end
    return main_bank[idx];
  endfunction

  task automatic store_reg(rindex_t idx, word_t value);
    if (is_banked(idx)) begin
      shadow_bank[idx] = value;
    end else begin
      main_bank[idx] = value;
    end
  endtask

  // Execute one command on the shadow copy of the register file.
  task automatic run_command(input cmd_t cmd, input rindex_t idx, input word_t value,
                             output result_t res);
    res.data = '0;
    res.code = ST_OK;
    case (cmd)
      CMD_READ: begin
        res.data = fetch_reg(idx);
      end
      CMD_WRITE: begin
        store_reg(idx, value);
      end
      CMD_ENTER: begin
        if (main_bank[REG_STATUS][IE_BIT]) begin
          shadow_bank[0] = main_bank[REG_STATUS];
          main_bank[REG_STATUS] = STATUS_IN_IRQ;
          // link goes through the new (banked) mapping
          store_reg(REG_LINK, main_bank[REG_PC]);
          main_bank[REG_PC] = PC_VECTOR;
        end else if (main_bank[REG_STATUS][BANK_BIT]) begin
          res.code = ST_IN_ROUTINE;
        end else begin
          res.code = ST_IE_CLEAR;
        end
      end
      default: begin
        if (!main_bank[REG_STATUS][BANK_BIT]) begin
          res.code = ST_EXIT_OUTSIDE;
        end
        main_bank[REG_PC] = fetch_reg(REG_LINK);
        main_bank[REG_STATUS] = fetch_reg(REG_BASE);
      end
    endcase
  endtask

  task automatic report(string msg);
    $display("%0t ns: MISMATCH %s", $time, msg);
    fail_count++;
  endtask

  always @(posedge clk) begin
    result_t want;
    if (rst) begin
      foreach (main_bank[i]) main_bank[i] = '0;
      foreach (shadow_bank[i]) shadow_bank[i] = '0;
      awaited_results.delete();
    end else begin
      if (s_tvalid && s_tready) begin
        run_command(cmd_t'(s_tdata[1:0]), rindex_t'(s_tdata[4:2]), word_t'(s_tdata[20:5]),
                    want);
        awaited_results.push_back(want);
      end
      if (m_tvalid && m_tready) begin
        if (awaited_results.size() == 0) begin
          report($sformatf("result word %h with no command pending", m_tdata));
        end else begin
          want = awaited_results.pop_front();
          if (m_tdata[15:0] !== want.data) begin
            report($sformatf("read_data got %h want %h", m_tdata[15:0], want.data));
          end
          if (m_tdata[17:16] !== want.code) begin
            report($sformatf("status got %0d want %0d", m_tdata[17:16], want.code));
          end
        end
      end
    end
    outstanding = awaited_results.size();
  end

endmodule

// File: verif/tb.sv
`timescale 1ns / 100ps

module tb;
  import brfi_pkg::*;

  localparam int    CYCLE_LIMIT  = 200000;
  localparam int    HOLD_CYCLES  = 60;
  localparam int    PHASE_WORDS  = 250;
  localparam word_t IE_MASK      = word_t'(1) << IE_BIT;
  localparam word_t BANK_MASK    = word_t'(1) << BANK_BIT;

  logic               clk;
  logic               rst;
  logic               s_tvalid;
  logic               s_tready;
  // [1:0] command, [4:2] reg_index, [20:5] write_value, [23:21] zero
  logic [TDATA_W-1:0] s_tdata;
  logic               m_tvalid;
  logic               m_tready;
  // [15:0] read_data, [17:16] status, [23:18] zero
  logic [TDATA_W-1:0] m_tdata;

  int fail_count;
  int outstanding;
  int words_sent  = 0;
  int tx_idle_pct = 0;
  int rx_idle_pct = 0;
  int holds_asked = 0;
  int holds_taken = 0;
  int cycle_count = 0;

  banked_register_file_interrupt DUT (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
  );

  regfile_checker checker_i (
    .clk         (clk),
    .rst         (rst),
    .s_tvalid    (s_tvalid),
    .s_tready    (s_tready),
    .s_tdata     (s_tdata),
    .m_tvalid    (m_tvalid),
    .m_tready    (m_tready),
    .m_tdata     (m_tdata),
    .fail_count  (fail_count),
    .outstanding (outstanding)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Watchdog: end the run if the block stops making progress.
  initial begin
    forever begin
      @(posedge clk);
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
        $display("Testbench completed WITH ERRORS");
        $finish;
      end
    end
  end

  // Result side: random back-pressure, plus a long hold-off when asked for.
  initial begin
    m_tready = 1'b0;
    forever begin
      @(posedge clk);
      if (holds_taken != holds_asked) begin
        holds_taken++;
        m_tready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
      end else begin
        m_tready <= ($urandom_range(99) >= rx_idle_pct);
      end
    end
  end

  // Offer one command word; idle first at the current sender rate, then hold
  // the word until it is taken.
  task automatic put_word(cmd_t cmd, rindex_t idx, word_t value);
    while ($urandom_range(99) < tx_idle_pct) begin
      s_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= {3'b000, value, idx, cmd};
    do @(posedge clk); while (!s_tready);
    words_sent++;
  endtask

  function automatic word_t rand_word();
    return word_t'($urandom);
  endfunction

  // Read or write a random register; status writes are optionally steered
  // to the PC so a routine does not lose its bank.
  task automatic plain_access(bit keep_status);
    rindex_t idx;
    idx = rindex_t'($urandom_range(REG_COUNT - 1));
    if ($urandom_range(1)) begin
      put_word(CMD_READ, idx, rand_word());
    end else begin
      if (keep_status && idx == REG_STATUS) begin
        idx = REG_PC;
      end
      put_word(CMD_WRITE, idx, rand_word());
    end
  endtask

  task automatic junk_word();
    put_word(cmd_t'($urandom_range(3)), rindex_t'($urandom_range(REG_COUNT - 1)),
             rand_word());
  endtask

  // A complete routine: arm the enable, enter, work in the shadow bank,
  // sometimes nest once, maybe try another entry, then exit.
  task automatic irq_routine();
    put_word(CMD_WRITE, REG_STATUS, (rand_word() & ~BANK_MASK) | IE_MASK);
    repeat ($urandom_range(3)) plain_access(1'b1);
    put_word(CMD_ENTER, rindex_t'($urandom_range(REG_COUNT - 1)), rand_word());
    repeat ($urandom_range(1, 5)) plain_access(1'b1);
    if ($urandom_range(3) == 0) begin
      put_word(CMD_WRITE, REG_STATUS, rand_word() | IE_MASK | BANK_MASK);
      put_word(CMD_ENTER, rindex_t'($urandom_range(REG_COUNT - 1)), rand_word());
      repeat ($urandom_range(0, 3)) plain_access(1'b1);
      put_word(CMD_EXIT, rindex_t'($urandom_range(REG_COUNT - 1)), rand_word());
    end
    // entry attempt inside the routine, refused while the enable is clear
    if ($urandom_range(4) == 0) begin
      put_word(CMD_ENTER, rindex_t'($urandom_range(REG_COUNT - 1)), rand_word());
    end
    put_word(CMD_EXIT, rindex_t'($urandom_range(REG_COUNT - 1)), rand_word());
    repeat ($urandom_range(2)) plain_access(1'b0);
  endtask

  initial begin
    rst      = 1'b1;
    s_tvalid = 1'b0;
    s_tdata  = '0;
    repeat (9) @(posedge clk);
    rst <= 1'b0;

    tx_idle_pct = 16;
    rx_idle_pct = 58;

    // Directed: refusals and exit from reset, a full entry and exit, the
    // routine's view of the banks, a nested entry and all-ones status.
    put_word(CMD_EXIT, REG_BASE, 16'h0000);         // exit outside routine
    put_word(CMD_ENTER, REG_PC, 16'hFFFF);          // enable and bank clear
    put_word(CMD_WRITE, REG_LINK, 16'hFFFF);
    put_word(CMD_WRITE, REG_PC, 16'hFFFF);
    put_word(CMD_WRITE, REG_STATUS, IE_MASK);
    put_word(CMD_ENTER, REG_BASE, 16'h0000);        // taken
    put_word(CMD_READ, REG_STATUS, 16'h0000);
    put_word(CMD_READ, REG_PC, 16'h0000);
    put_word(CMD_READ, REG_LINK, 16'h0000);          // link in shadow bank
    put_word(CMD_READ, REG_BASE, 16'h0000);          // saved status
    put_word(CMD_ENTER, REG_BASE, 16'h0000);        // in routine, no enable
    put_word(CMD_WRITE, rindex_t'(3), 16'hA5A5);
    put_word(CMD_READ, rindex_t'(3), 16'h0000);
    put_word(CMD_WRITE, REG_STATUS, IE_MASK | BANK_MASK);
    put_word(CMD_ENTER, REG_BASE, 16'h0000);        // nested entry
    put_word(CMD_EXIT, REG_BASE, 16'h0000);
    put_word(CMD_WRITE, REG_BASE, 16'h0000);
    put_word(CMD_EXIT, REG_BASE, 16'h0000);         // back to main bank
    put_word(CMD_READ, REG_LINK, 16'h0000);
    put_word(CMD_READ, rindex_t'(3), 16'h0000);
    put_word(CMD_WRITE, REG_STATUS, 16'hFFFF);
    put_word(CMD_READ, REG_STATUS, 16'h0000);
    put_word(CMD_ENTER, REG_BASE, 16'h0000);
    put_word(CMD_EXIT, REG_BASE, 16'h0000);
    put_word(CMD_WRITE, REG_STATUS, 16'h0000);

    // Random: mostly complete routines, the rest junk. Phases 0 and 1 swap
    // idle rates; phase 2 drops them and holds off the result side a while.
    for (int phase = 0; phase < 3; phase++) begin
      case (phase)
        0: begin
          tx_idle_pct = 16;
          rx_idle_pct = 58;
        end
        1: begin
          tx_idle_pct = 58;
          rx_idle_pct = 16;
        end
        default: begin
          tx_idle_pct = 0;
          rx_idle_pct = 0;
          holds_asked++;
        end
      endcase
      while (words_sent < 25 + PHASE_WORDS * (phase + 1)) begin
        if ($urandom_range(9) < 7) begin
          irq_routine();
        end else begin
          repeat ($urandom_range(1, 4)) junk_word();
        end
      end
    end

    s_tvalid <= 1'b0;
    // drain, then let the pipeline settle
    while (outstanding != 0) @(posedge clk);
    repeat (5) @(posedge clk);
    if (fail_count == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
